/* rtl/rsqs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the rotating slot quiet scheduler.
// No dependencies; every rtl/ file refers to it by scoped names.
package rsqs_pkg;

   // Time unit is 1024 us.
   localparam int unsigned TuShift = 10;

   typedef enum logic [1:0] {
      CMD_REARM   = 2'd0,
      CMD_RECOVER = 2'd1,
      CMD_DISARM  = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NOTHING  = 2'd0,
      ACT_ARMED    = 2'd1,
      ACT_DISARMED = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      CSR_LEASE_ENABLE      = 3'd0,
      CSR_SLOT_COUNT_LOG2   = 3'd1,
      CSR_SLOT_LEN_LOG2     = 3'd2,
      CSR_BASE_SLOT         = 3'd3,
      CSR_QUIET_DISABLED    = 3'd4,
      CSR_ARM_MARGIN_US     = 3'd5,
      CSR_FIXED_PERIOD_TU   = 3'd6,
      CSR_FIXED_DURATION_TU = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        lease_enable;
      logic [3:0]  slot_count_log2;
      logic [2:0]  slot_len_log2;
      logic [7:0]  base_slot;
      logic        quiet_disabled;
      logic [15:0] arm_margin_us;
      logic [15:0] fixed_period_tu;
      logic [15:0] fixed_duration_tu;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] now_us;
      logic        timer_on_readback;
   } req_type;

   // Slot geometry for the current time, all modulo 2^32.
   typedef struct packed {
      logic [31:0] epoch;
      logic [7:0]  slot_lo;
      logic [31:0] slot_us;
      logic [31:0] per_us;
      logic [31:0] win_open;
      logic [31:0] win_close;
      logic [31:0] succ_open;
   } geo_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] quiet_start_us;
      logic [31:0] quiet_period_us;
      logic [15:0] quiet_len_tu;
      logic        tick_valid;
      logic [31:0] tick_time_us;
      logic [7:0]  slot_index;
      logic [31:0] epoch_index;
   } rsp_type;

endpackage

/* rtl/rotating_slot_quiet_scheduler_top.sv */
`timescale 1ns / 1ps
// Top level of the rotating slot quiet scheduler: ports, CSRs, request and
// response registers. Depends on rsqs_pkg, rsqs_geometry and rsqs_core.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  request  | req_tvalid/tready   | req_tuser cmd, req_tdata now_us, readback
//  response | rsp_tvalid/tready   | rsp_tuser action, rsp_tdata window + slot
//  csr      | csr_we              | csr_addr register index, csr_wdata value
//
// One request per cycle sustained while rsp_tready stays high; a request passes
// the request register, then the decision logic into the response register.
// Reset is synchronous and active high; it restores the CSR defaults and
// clears the armed state and both valid flags.
// A stalled response holds only the response register; the request register
// keeps accepting while it is empty, so one request is taken under a stall.
module rotating_slot_quiet_scheduler_top #(
   parameter int unsigned MAX_SLOTS_LOG2 = 8
) (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // [1:0] cmd
   input  logic [39:0]  req_tdata,   // [31:0] now_us, [32] timer_on_readback, rest 0
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // [1:0] action
   // [31:0] quiet_start_us, [63:32] quiet_period_us, [79:64] quiet_len_tu,
   // [80] tick_valid, [112:81] tick_time_us, [120:113] slot_index,
   // [152:121] epoch_index, rest 0
   output logic [159:0] rsp_tdata,
   // CSR write port
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   // ---------------------------------------------------------------- CSRs
   rsqs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lease_enable <= 1'b0;
         cfg_ff.slot_count_log2 <= 4'd2;
         cfg_ff.slot_len_log2 <= 3'd0;
         cfg_ff.base_slot <= 8'd0;
         cfg_ff.quiet_disabled <= 1'b0;
         cfg_ff.arm_margin_us <= 16'd2048;
         cfg_ff.fixed_period_tu <= 16'd0;
         cfg_ff.fixed_duration_tu <= 16'd0;
      end else if (csr_we) begin
         unique case (rsqs_pkg::csr_index_type'(csr_addr))
            rsqs_pkg::CSR_LEASE_ENABLE:      cfg_ff.lease_enable <= csr_wdata[0];
            rsqs_pkg::CSR_SLOT_COUNT_LOG2:   cfg_ff.slot_count_log2 <= csr_wdata[3:0];
            rsqs_pkg::CSR_SLOT_LEN_LOG2:     cfg_ff.slot_len_log2 <= csr_wdata[2:0];
            rsqs_pkg::CSR_BASE_SLOT:         cfg_ff.base_slot <= csr_wdata[7:0];
            rsqs_pkg::CSR_QUIET_DISABLED:    cfg_ff.quiet_disabled <= csr_wdata[0];
            rsqs_pkg::CSR_ARM_MARGIN_US:     cfg_ff.arm_margin_us <= csr_wdata;
            rsqs_pkg::CSR_FIXED_PERIOD_TU:   cfg_ff.fixed_period_tu <= csr_wdata;
            rsqs_pkg::CSR_FIXED_DURATION_TU: cfg_ff.fixed_duration_tu <= csr_wdata;
         endcase
      end
   end

   // ------------------------------------------------------------ pipeline
   logic              req_vld_ff, req_vld_in;
   rsqs_pkg::req_type req_q_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   rsqs_pkg::rsp_type rsp_q_ff;
   logic              advance;
   logic              req_fire;

   rsqs_pkg::geo_type geo;
   rsqs_pkg::rsp_type rsp_next;

   // response slot free or draining this cycle
   assign advance = !rsp_vld_ff || rsp_tready;
   assign req_tready = !req_vld_ff || advance;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      req_vld_in = req_tready ? req_tvalid : req_vld_ff;
      rsp_vld_in = advance ? req_vld_ff : rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_q_ff.cmd <= rsqs_pkg::cmd_type'(req_tuser);
         req_q_ff.now_us <= req_tdata[31:0];
         req_q_ff.timer_on_readback <= req_tdata[32];
      end
      if (advance && req_vld_ff) begin
         rsp_q_ff <= rsp_next;
      end
   end

   rsqs_geometry #(
      .MAX_SLOTS_LOG2(MAX_SLOTS_LOG2)
   ) u_geometry (
      .cfg    (cfg_ff),
      .now_us (req_q_ff.now_us),
      .geo    (geo)
   );

   // state commits as the request moves into the response register
   rsqs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .upd_en (req_vld_ff && advance),
      .cfg    (cfg_ff),
      .req    (req_q_ff),
      .geo    (geo),
      .rsp    (rsp_next)
   );

   // ------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser = rsp_q_ff.action;
   assign rsp_tdata = {7'd0,
                       rsp_q_ff.epoch_index,
                       rsp_q_ff.slot_index,
                       rsp_q_ff.tick_time_us,
                       rsp_q_ff.tick_valid,
                       rsp_q_ff.quiet_len_tu,
                       rsp_q_ff.quiet_period_us,
                       rsp_q_ff.quiet_start_us};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_moves_on: assert property (@(posedge clock) disable iff (reset)
      req_vld_ff && advance |=> rsp_vld_ff)
      else $error("request lost between stages");

   a_idle_window_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_q_ff.action != rsqs_pkg::ACT_ARMED)
      |-> (rsp_q_ff.quiet_start_us == 32'd0) && !rsp_q_ff.tick_valid
          && (rsp_q_ff.tick_time_us == 32'd0))
      else $error("window fields set without an arm");

endmodule

/* rtl/rsqs_geometry.sv */
`timescale 1ns / 1ps
// Epoch, rotated slot and slot window boundaries from the current time.
// Depends on rsqs_pkg. Pure shifts, adds and masks; no multipliers.
module rsqs_geometry #(
   parameter int unsigned MAX_SLOTS_LOG2 = 8
) (
   input  rsqs_pkg::cfg_type cfg,
   input  logic [31:0]       now_us,
   output rsqs_pkg::geo_type geo
);

   localparam logic [4:0] MaxScl = 5'(MAX_SLOTS_LOG2);

   logic [4:0]  scl;
   logic [5:0]  ep_log2;
   logic        ep_wide;
   logic [31:0] slot_mask;
   logic [31:0] epoch;
   logic [31:0] slot;
   logic [31:0] succ_slot;
   logic [31:0] slot_us;

   always_comb begin
      scl = ({1'b0, cfg.slot_count_log2} > MaxScl) ? MaxScl : {1'b0, cfg.slot_count_log2};
      ep_log2 = 6'(rsqs_pkg::TuShift) + {3'b0, cfg.slot_len_log2} + {1'b0, scl};
      ep_wide = (ep_log2 >= 6'd32);
      slot_mask = (32'd1 << scl) - 32'd1;
      epoch = ep_wide ? 32'd0 : (now_us >> ep_log2[4:0]);
      slot = (32'(cfg.base_slot) + epoch) & slot_mask;
      succ_slot = (32'(cfg.base_slot) + epoch + 32'd1) & slot_mask;
      slot_us = 32'd1024 << cfg.slot_len_log2;

      geo.epoch = epoch;
      geo.slot_lo = slot[7:0];
      geo.slot_us = slot_us;
      geo.per_us = ep_wide ? 32'd0 : (32'd1 << ep_log2[4:0]);
      // slot * slot_us == slot << (10 + L)
      geo.win_open = (ep_wide ? 32'd0 : (epoch << ep_log2[4:0]))
                     + ((slot << rsqs_pkg::TuShift) << cfg.slot_len_log2);
      geo.win_close = geo.win_open + slot_us;
      geo.succ_open = (ep_wide ? 32'd0 : ((epoch + 32'd1) << ep_log2[4:0]))
                      + ((succ_slot << rsqs_pkg::TuShift) << cfg.slot_len_log2);
   end

endmodule

/* rtl/rsqs_core.sv */
`timescale 1ns / 1ps
// Command decode, arm/disarm decision and the armed / armed_epoch state.
// Depends on rsqs_pkg; takes geometry from rsqs_geometry.
module rsqs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              upd_en,
   input  rsqs_pkg::cfg_type cfg,
   input  rsqs_pkg::req_type req,
   input  rsqs_pkg::geo_type geo,
   output rsqs_pkg::rsp_type rsp
);

   logic        armed_ff, armed_in;
   logic [31:0] armed_epoch_ff, armed_epoch_in;

   logic        lease_outside;
   logic        wrap_empty;
   logic [31:0] next_us;
   logic [31:0] rep_us;
   logic [31:0] dur_full;
   logic [31:0] tick_quarter;

   always_comb begin
      lease_outside = (req.now_us < geo.win_open) || (req.now_us >= geo.win_close);
      wrap_empty = (geo.succ_open <= geo.win_close);
      if (cfg.lease_enable) begin
         next_us = geo.win_close;
         rep_us = geo.per_us + geo.slot_us;
         dur_full = (geo.succ_open - geo.win_close) >> rsqs_pkg::TuShift;
         tick_quarter = geo.slot_us >> 2;
      end else begin
         next_us = req.now_us + 32'(cfg.arm_margin_us);
         rep_us = 32'(cfg.fixed_period_tu) << rsqs_pkg::TuShift;
         dur_full = 32'(cfg.fixed_duration_tu);
         tick_quarter = 32'd256;
      end
   end

   logic do_rearm, armed_eff, pass_guard, arm;

   always_comb begin
      rsp = '0;
      armed_in = armed_ff;
      armed_epoch_in = armed_epoch_ff;
      do_rearm = 1'b0;
      armed_eff = armed_ff;
      arm = 1'b0;

      case (req.cmd)
         rsqs_pkg::CMD_REARM: do_rearm = 1'b1;
         rsqs_pkg::CMD_RECOVER: begin
            // timer lost or never armed: forget the arm, then try again
            if (!(armed_ff && req.timer_on_readback)) begin
               armed_eff = 1'b0;
               armed_in = 1'b0;
               do_rearm = 1'b1;
            end
         end
         rsqs_pkg::CMD_DISARM: begin
            armed_in = 1'b0;
            rsp.action = rsqs_pkg::ACT_DISARMED;
         end
         default: ;
      endcase

      pass_guard = do_rearm && !cfg.quiet_disabled
                   && !(!cfg.lease_enable && (cfg.fixed_period_tu == 16'd0))
                   && !(armed_eff && req.timer_on_readback
                        && !(cfg.lease_enable && (geo.epoch != armed_epoch_ff)));

      if (pass_guard) begin
         if (cfg.lease_enable) begin
            if (!(armed_eff && lease_outside)) begin
               armed_epoch_in = geo.epoch;
               if (wrap_empty) begin
                  armed_in = 1'b0;
                  rsp.action = rsqs_pkg::ACT_DISARMED;
               end else begin
                  arm = 1'b1;
               end
            end
         end else begin
            arm = 1'b1;
         end
      end

      if (arm) begin
         armed_in = 1'b1;
         rsp.action = rsqs_pkg::ACT_ARMED;
         rsp.quiet_start_us = next_us;
         rsp.quiet_period_us = rep_us;
         rsp.quiet_len_tu = (dur_full > 32'h0000_FFFF) ? 16'hFFFF : dur_full[15:0];
         if (rep_us > 32'(cfg.arm_margin_us)) begin
            rsp.tick_valid = 1'b1;
            rsp.tick_time_us = next_us + (dur_full << rsqs_pkg::TuShift) + tick_quarter;
         end
      end

      if (cfg.lease_enable) begin
         rsp.slot_index = geo.slot_lo;
         rsp.epoch_index = geo.epoch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         armed_epoch_ff <= 32'd0;
      end else if (upd_en) begin
         armed_ff <= armed_in;
         armed_epoch_ff <= armed_epoch_in;
      end
   end

   a_arm_sets: assert property (@(posedge clock) disable iff (reset)
      upd_en && (rsp.action == rsqs_pkg::ACT_ARMED) |=> armed_ff)
      else $error("armed flag not set after arming");

   a_disarm_clears: assert property (@(posedge clock) disable iff (reset)
      upd_en && (rsp.action == rsqs_pkg::ACT_DISARMED) |=> !armed_ff)
      else $error("armed flag still set after disarm");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !upd_en |=> $stable(armed_ff) && $stable(armed_epoch_ff))
      else $error("scheduler state changed without a request");

endmodule
